>>> sv/lavb_pkg.sv
// Shared constants, types and rounding and saturation helpers of the look-at view basis block.
package lavb_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int COORD_W = 32;
  // Magnitudes are scaled so that the largest one has its top bit here, plus one.
  localparam int NORM_W = 30;

  typedef logic [1:0] row_sel_t;

  localparam row_sel_t ROW_SIDE = 2'd0;
  localparam row_sel_t ROW_UP   = 2'd1;
  localparam row_sel_t ROW_FWD  = 2'd2;

  // Rounds to nearest, ties away from zero, dropping the given number of fraction bits.
  function automatic logic signed [63:0] round_frac(input logic signed [63:0] v,
                                                    input int unsigned f);
    logic [63:0] m;
    logic [63:0] r;
    m = v[63] ? 64'(-v) : 64'(v);
    r = (m + (64'd1 << (f - 1))) >> f;
    return v[63] ? $signed(-r) : $signed(r);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end
    if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end
    return $signed(v[31:0]);
  endfunction

endpackage

>>> sv/lavb_if.sv
// Stream interfaces for the point set input and the row output of the block.
interface lavb_pt_if;
  logic valid;
  logic ready;
  logic signed [lavb_pkg::COORD_W-1:0] eye_x;
  logic signed [lavb_pkg::COORD_W-1:0] eye_y;
  logic signed [lavb_pkg::COORD_W-1:0] eye_z;
  logic signed [lavb_pkg::COORD_W-1:0] aim_x;
  logic signed [lavb_pkg::COORD_W-1:0] aim_y;
  logic signed [lavb_pkg::COORD_W-1:0] aim_z;
  logic signed [lavb_pkg::COORD_W-1:0] upward_x;
  logic signed [lavb_pkg::COORD_W-1:0] upward_y;
  logic signed [lavb_pkg::COORD_W-1:0] upward_z;

  modport source(output valid, eye_x, eye_y, eye_z, aim_x, aim_y, aim_z,
                 upward_x, upward_y, upward_z, input ready);
  modport sink(input valid, eye_x, eye_y, eye_z, aim_x, aim_y, aim_z,
               upward_x, upward_y, upward_z, output ready);
endinterface

interface lavb_row_if;
  logic valid;
  logic ready;
  lavb_pkg::row_sel_t row_index;
  logic signed [lavb_pkg::COORD_W-1:0] comp_x;
  logic signed [lavb_pkg::COORD_W-1:0] comp_y;
  logic signed [lavb_pkg::COORD_W-1:0] comp_z;
  logic signed [lavb_pkg::COORD_W-1:0] offset;
  logic degenerate;
  logic last_row;

  modport source(output valid, row_index, comp_x, comp_y, comp_z, offset,
                 degenerate, last_row, input ready);
  modport sink(input valid, row_index, comp_x, comp_y, comp_z, offset,
               degenerate, last_row, output ready);
endinterface

>>> sv/lavb_norm.sv
// Pipelined vector normaliser: scaling, sum of squares, square root and division.
module lavb_norm #(
  parameter int W  = 33,
  parameter int F  = lavb_pkg::FRAC_BITS_DEF,
  parameter int SW = 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic signed [W-1:0] vec [3],
  input  logic [SW-1:0]       in_side,
  output logic                out_valid,
  output logic signed [F+1:0] unit [3],
  output logic                zero,
  output logic [SW-1:0]       out_side
);

  localparam int MW   = lavb_pkg::NORM_W;
  localparam int TOPB = MW - 1;
  localparam int PW   = $clog2(W);
  localparam int SQW  = 2 * MW;
  localparam int NRW  = SQW + 3;
  localparam int RB   = MW + 1;
  localparam int QW   = F + 1;
  localparam int NW   = MW + F + 2;

  typedef struct packed {
    logic [2:0]    neg;
    logic          zero;
    logic [SW-1:0] side;
  } tag_t;

  function automatic logic [PW-1:0] msb_of(input logic [W-1:0] x);
    logic [PW-1:0] p;
    p = '0;
    for (int b = 0; b < W; b++) begin
      if (x[b]) begin
        p = PW'(b);
      end
    end
    return p;
  endfunction

  logic                   v0, v1, v2, v3, v4;
  tag_t                   t0, t1, t2, t3, t4;
  logic [2:0][W-1:0]      mag0, mag1, mag2;
  logic [W-1:0]           top_c, top1;
  logic [PW-1:0]          pos2;
  logic [2:0][MW-1:0]     m3, m4;
  logic [2:0][SQW-1:0]    sq4;

  logic                   sv [RB+1];
  tag_t                   st [RB+1];
  logic [2:0][MW-1:0]     sm [RB+1];
  logic [NRW-1:0]         sn [RB];
  logic [NRW-1:0]         sr [RB+1];

  logic                   dv [QW+1];
  tag_t                   dt [QW+1];
  logic [RB-1:0]          dl [QW];
  logic [2:0][NW-1:0]     dn [QW];
  logic [2:0][QW-1:0]     dq [QW+1];

  // Valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      sv[0] <= 1'b0;
      dv[0] <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v0 <= in_valid;
      v1 <= v0;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      sv[0] <= v4;
      dv[0] <= sv[RB];
      out_valid <= dv[QW];
    end
  end

  always_comb begin
    top_c = mag0[0];
    if (mag0[1] > top_c) begin
      top_c = mag0[1];
    end
    if (mag0[2] > top_c) begin
      top_c = mag0[2];
    end
  end

  // Magnitudes, largest magnitude, its top bit, scaling, squares and their sum.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        mag0[i] <= vec[i][W-1] ? W'(-vec[i]) : W'(vec[i]);
        t0.neg[i] <= vec[i][W-1];
      end
      t0.zero <= (vec[0] == '0) && (vec[1] == '0) && (vec[2] == '0);
      t0.side <= in_side;

      mag1 <= mag0;
      top1 <= top_c;
      t1 <= t0;

      mag2 <= mag1;
      pos2 <= msb_of(top1);
      t2 <= t1;

      for (int i = 0; i < 3; i++) begin
        if (pos2 >= PW'(TOPB)) begin
          m3[i] <= MW'(mag2[i] >> (pos2 - PW'(TOPB)));
        end else begin
          m3[i] <= MW'({{MW{1'b0}}, mag2[i]} << (PW'(TOPB) - pos2));
        end
      end
      t3 <= t2;

      for (int i = 0; i < 3; i++) begin
        sq4[i] <= m3[i] * m3[i];
      end
      m4 <= m3;
      t4 <= t3;

      sn[0] <= NRW'(sq4[0]) + NRW'(sq4[1]) + NRW'(sq4[2]);
      sr[0] <= '0;
      sm[0] <= m4;
      st[0] <= t4;
    end
  end

  // Square root, one result bit per stage.
  for (genvar k = 0; k < RB; k++) begin : g_sqrt
    localparam logic [NRW-1:0] BITV = NRW'(1) << (2 * (RB - 1 - k));
    logic [NRW-1:0] trial;
    logic           take;

    assign trial = sr[k] + BITV;
    assign take  = (sn[k] >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        sv[k+1] <= 1'b0;
      end else if (en) begin
        sv[k+1] <= sv[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st[k+1] <= st[k];
        sm[k+1] <= sm[k];
        sr[k+1] <= take ? (sr[k] >> 1) + BITV : sr[k] >> 1;
      end
    end

    if (k < RB - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          sn[k+1] <= take ? sn[k] - trial : sn[k];
        end
      end
    end
  end

  // Division set-up: scaled magnitude plus half the length.
  always_ff @(posedge clk) begin
    if (en) begin
      dt[0] <= st[RB];
      dl[0] <= sr[RB][RB-1:0];
      for (int i = 0; i < 3; i++) begin
        dn[0][i] <= (NW'(sm[RB][i]) << F) + NW'(sr[RB][RB-1:1]);
      end
      dq[0] <= '0;
    end
  end

  // Restoring division, one quotient bit per stage for all three components.
  for (genvar j = 0; j < QW; j++) begin : g_div
    localparam int SH = QW - 1 - j;
    logic [2:0] take;

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        take[i] = (dn[j][i] >= (NW'(dl[j]) << SH));
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[j+1] <= 1'b0;
      end else if (en) begin
        dv[j+1] <= dv[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dt[j+1] <= dt[j];
        for (int i = 0; i < 3; i++) begin
          dq[j+1][i] <= take[i] ? (dq[j][i] | (QW'(1) << SH)) : dq[j][i];
        end
      end
    end

    if (j < QW - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          dl[j+1] <= dl[j];
          for (int i = 0; i < 3; i++) begin
            dn[j+1][i] <= take[i] ? dn[j][i] - (NW'(dl[j]) << SH) : dn[j][i];
          end
        end
      end
    end
  end

  // Sign restored; a zero vector gives a zero result.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        if (dt[QW].zero) begin
          unit[i] <= '0;
        end else if (dt[QW].neg[i]) begin
          unit[i] <= -$signed({1'b0, dq[QW][i]});
        end else begin
          unit[i] <= $signed({1'b0, dq[QW][i]});
        end
      end
      zero <= dt[QW].zero;
      out_side <= dt[QW].side;
    end
  end

endmodule

>>> sv/lavb_cross.sv
// Two-stage cross product of the forward vector with the reference up vector.
module lavb_cross #(
  parameter int F  = lavb_pkg::FRAC_BITS_DEF,
  parameter int SW = 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic signed [F+1:0]  f [3],
  input  logic signed [lavb_pkg::COORD_W-1:0] up [3],
  input  logic [SW-1:0]        in_side,
  output logic                 out_valid,
  output logic signed [F+33:0] c [3],
  output logic [SW-1:0]        out_side
);

  localparam int PRW = F + 2 + lavb_pkg::COORD_W;
  localparam int CW  = F + 34;

  logic                  v1;
  logic signed [PRW-1:0] p [6];
  logic [SW-1:0]         side1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p[0] <= f[1] * up[2];
      p[1] <= f[2] * up[1];
      p[2] <= f[2] * up[0];
      p[3] <= f[0] * up[2];
      p[4] <= f[0] * up[1];
      p[5] <= f[1] * up[0];
      side1 <= in_side;

      for (int i = 0; i < 3; i++) begin
        c[i] <= CW'(p[2*i]) - CW'(p[2*i+1]);
      end
      out_side <= side1;
    end
  end

endmodule

>>> sv/lavb_rows.sv
// Row assembly: true up vector, dot products with the eye, rounding and saturation.
module lavb_rows #(
  parameter int F = lavb_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic signed [F+1:0] s [3],
  input  logic signed [F+1:0] f [3],
  input  logic signed [lavb_pkg::COORD_W-1:0] eye [3],
  input  logic                degen,
  output logic                out_valid,
  output logic signed [lavb_pkg::COORD_W-1:0] row_s [3],
  output logic signed [lavb_pkg::COORD_W-1:0] row_u [3],
  output logic signed [lavb_pkg::COORD_W-1:0] row_f [3],
  output logic signed [lavb_pkg::COORD_W-1:0] offs [3],
  output logic                out_degen
);

  localparam int EW  = lavb_pkg::COORD_W;
  localparam int FW  = F + 2;
  localparam int PW  = 2 * FW;
  localparam int SEW = FW + EW;
  localparam int UW  = F + 3;
  localparam int UEW = UW + EW;
  localparam int DW  = F + 37;

  logic v1, v2, v3, v4;
  logic signed [PW-1:0]  psf1 [6];
  logic signed [SEW-1:0] pse1 [3];
  logic signed [SEW-1:0] pfe1 [3];
  logic signed [FW-1:0]  s1 [3], s2 [3], s3 [3], s4 [3];
  logic signed [FW-1:0]  f1 [3], f2 [3], f3 [3], f4 [3];
  logic signed [EW-1:0]  eye1 [3], eye2 [3];
  logic signed [UW-1:0]  u2 [3], u3 [3], u4 [3];
  logic signed [DW-1:0]  ds2, df2, du4;
  logic signed [UEW-1:0] pue3 [3];
  logic signed [EW-1:0]  os3, of3, os4, of4;
  logic                  dg1, dg2, dg3, dg4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      out_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // Products for s x f and for the side and forward dot products.
      psf1[0] <= s[1] * f[2];
      psf1[1] <= s[2] * f[1];
      psf1[2] <= s[2] * f[0];
      psf1[3] <= s[0] * f[2];
      psf1[4] <= s[0] * f[1];
      psf1[5] <= s[1] * f[0];
      for (int i = 0; i < 3; i++) begin
        pse1[i] <= s[i] * eye[i];
        pfe1[i] <= f[i] * eye[i];
      end
      s1 <= s;
      f1 <= f;
      eye1 <= eye;
      dg1 <= degen;

      for (int i = 0; i < 3; i++) begin
        u2[i] <= UW'(lavb_pkg::round_frac(64'(psf1[2*i]) - 64'(psf1[2*i+1]), F));
      end
      ds2 <= DW'(pse1[0]) + DW'(pse1[1]) + DW'(pse1[2]);
      df2 <= DW'(pfe1[0]) + DW'(pfe1[1]) + DW'(pfe1[2]);
      s2 <= s1;
      f2 <= f1;
      eye2 <= eye1;
      dg2 <= dg1;

      for (int i = 0; i < 3; i++) begin
        pue3[i] <= u2[i] * eye2[i];
      end
      os3 <= lavb_pkg::sat32(lavb_pkg::round_frac(-64'(ds2), F));
      of3 <= lavb_pkg::sat32(lavb_pkg::round_frac(64'(df2), F));
      s3 <= s2;
      f3 <= f2;
      u3 <= u2;
      dg3 <= dg2;

      du4 <= DW'(pue3[0]) + DW'(pue3[1]) + DW'(pue3[2]);
      os4 <= os3;
      of4 <= of3;
      s4 <= s3;
      f4 <= f3;
      u4 <= u3;
      dg4 <= dg3;

      offs[0] <= os4;
      offs[1] <= lavb_pkg::sat32(lavb_pkg::round_frac(-64'(du4), F));
      offs[2] <= of4;
      for (int i = 0; i < 3; i++) begin
        row_s[i] <= EW'(s4[i]);
        row_u[i] <= EW'(u4[i]);
        row_f[i] <= EW'(-f4[i]);
      end
      out_degen <= dg4;
    end
  end

endmodule

>>> sv/look_at_view_basis.sv
// Top level of the look-at view basis block: pipeline and row output register.
//
// Each transfer on points carries an eye position, a target point and a
// reference up vector in signed fixed point with FRAC_BITS fraction bits.
// For each one the block sends three transfers on rows, in order: the side
// row (row_index 0), the true up row (1) and the negated forward row (2,
// last_row set), each with its saturated translation offset and the same
// degenerate flag. Most of the pipeline depth between a point set being
// taken and its first row leaving comes from the two normalisers, each of
// which holds a square root with one result bit per stage and a divider
// with one quotient bit per stage. With rows.ready held high the block
// takes a new point set each time the last row of the held item leaves,
// one for every three row transfers on the output. The whole pipeline
// moves together: it halts while the output register holds an item whose
// last row is not being taken, and points.ready is low in those cycles.
module look_at_view_basis #(
  parameter int FRAC_BITS = lavb_pkg::FRAC_BITS_DEF
) (
  input logic        clk,
  input logic        rst,
  lavb_pt_if.sink    points,
  lavb_row_if.source rows
);

  localparam int CW  = lavb_pkg::COORD_W;
  localparam int FW  = FRAC_BITS + 2;
  localparam int DW  = CW + 1;
  localparam int XW  = FRAC_BITS + 34;
  localparam int S1W = 6 * CW;
  localparam int S2W = 3 * CW + 3 * FW + 1;

  logic en;

  // Direction from eye to target, with eye and up riding alongside.
  logic                  v0;
  logic signed [DW-1:0]  dir0 [3];
  logic [S1W-1:0]        side0;

  // After the forward normaliser.
  logic                  v1;
  logic signed [FW-1:0]  fwd1 [3];
  logic                  z1;
  logic [S1W-1:0]        side1;
  logic signed [CW-1:0]  up1 [3];
  logic [S2W-1:0]        side1x;

  // After the cross product.
  logic                  v2;
  logic signed [XW-1:0]  cr2 [3];
  logic [S2W-1:0]        side2;

  // After the side normaliser.
  logic                  v3;
  logic signed [FW-1:0]  s3 [3];
  logic signed [FW-1:0]  f3 [3];
  logic signed [CW-1:0]  eye3 [3];
  logic                  z2;
  logic [S2W-1:0]        side3;

  // Finished rows.
  logic                  v4;
  logic signed [CW-1:0]  row_s4 [3], row_u4 [3], row_f4 [3], offs4 [3];
  logic                  dg4;

  // Output register.
  logic                  hv;
  lavb_pkg::row_sel_t    row;
  logic signed [CW-1:0]  hs [3], hu [3], hf [3], hoff [3];
  logic                  hdeg;

  // The pipeline advances when the output register is empty or its last
  // row is being transferred.
  assign en = !hv || (rows.ready && (row == lavb_pkg::ROW_FWD));
  assign points.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= points.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dir0[0] <= DW'(points.aim_x) - DW'(points.eye_x);
      dir0[1] <= DW'(points.aim_y) - DW'(points.eye_y);
      dir0[2] <= DW'(points.aim_z) - DW'(points.eye_z);
      side0 <= {points.eye_x, points.eye_y, points.eye_z,
                points.upward_x, points.upward_y, points.upward_z};
    end
  end

  lavb_norm #(.W(DW), .F(FRAC_BITS), .SW(S1W)) u_fwd_norm (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(v0), .vec(dir0), .in_side(side0),
    .out_valid(v1), .unit(fwd1), .zero(z1), .out_side(side1)
  );

  assign up1[0] = $signed(side1[3*CW-1 -: CW]);
  assign up1[1] = $signed(side1[2*CW-1 -: CW]);
  assign up1[2] = $signed(side1[CW-1 -: CW]);
  // Eye, forward vector and the forward degenerate flag travel on.
  assign side1x = {side1[6*CW-1 -: 3*CW], fwd1[0], fwd1[1], fwd1[2], z1};

  lavb_cross #(.F(FRAC_BITS), .SW(S2W)) u_cross (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(v1), .f(fwd1), .up(up1), .in_side(side1x),
    .out_valid(v2), .c(cr2), .out_side(side2)
  );

  lavb_norm #(.W(XW), .F(FRAC_BITS), .SW(S2W)) u_side_norm (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(v2), .vec(cr2), .in_side(side2),
    .out_valid(v3), .unit(s3), .zero(z2), .out_side(side3)
  );

  assign eye3[0] = $signed(side3[S2W-1 -: CW]);
  assign eye3[1] = $signed(side3[S2W-CW-1 -: CW]);
  assign eye3[2] = $signed(side3[S2W-2*CW-1 -: CW]);
  assign f3[0]   = $signed(side3[3*FW -: FW]);
  assign f3[1]   = $signed(side3[2*FW -: FW]);
  assign f3[2]   = $signed(side3[FW -: FW]);

  lavb_rows #(.F(FRAC_BITS)) u_rows (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(v3), .s(s3), .f(f3), .eye(eye3), .degen(z2 | side3[0]),
    .out_valid(v4), .row_s(row_s4), .row_u(row_u4), .row_f(row_f4),
    .offs(offs4), .out_degen(dg4)
  );

  // The output register holds one item and steps through its three rows.
  always_ff @(posedge clk) begin
    if (rst) begin
      hv <= 1'b0;
      row <= lavb_pkg::ROW_SIDE;
    end else if (en) begin
      hv <= v4;
      row <= lavb_pkg::ROW_SIDE;
    end else if (rows.ready) begin
      row <= row + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hs <= row_s4;
      hu <= row_u4;
      hf <= row_f4;
      hoff <= offs4;
      hdeg <= dg4;
    end
  end

  always_comb begin
    rows.valid = hv;
    rows.row_index = row;
    rows.degenerate = hdeg;
    rows.last_row = (row == lavb_pkg::ROW_FWD);
    case (row)
      lavb_pkg::ROW_SIDE: begin
        rows.comp_x = hs[0];
        rows.comp_y = hs[1];
        rows.comp_z = hs[2];
        rows.offset = hoff[0];
      end
      lavb_pkg::ROW_UP: begin
        rows.comp_x = hu[0];
        rows.comp_y = hu[1];
        rows.comp_z = hu[2];
        rows.offset = hoff[1];
      end
      lavb_pkg::ROW_FWD: begin
        rows.comp_x = hf[0];
        rows.comp_y = hf[1];
        rows.comp_z = hf[2];
        rows.offset = hoff[2];
      end
      default: begin
        rows.comp_x = '0;
        rows.comp_y = '0;
        rows.comp_z = '0;
        rows.offset = '0;
      end
    endcase
  end

endmodule

>>> sv/lavb_check.sv
// Port checker for the row output of the look-at view basis block, with its bind.
module lavb_check (
  input logic                         clk,
  input logic                         rst,
  input logic                         valid,
  input logic                         ready,
  input lavb_pkg::row_sel_t           row_index,
  input logic signed [lavb_pkg::COORD_W-1:0] comp_x,
  input logic signed [lavb_pkg::COORD_W-1:0] comp_y,
  input logic signed [lavb_pkg::COORD_W-1:0] comp_z,
  input logic signed [lavb_pkg::COORD_W-1:0] offset,
  input logic                         degenerate,
  input logic                         last_row
);

  // Nothing is offered in the cycle after reset.
  a_reset_idle: assert property (@(posedge clk) rst |=> !valid)
    else $error("row output valid straight after reset");

  // A row that is not taken stays as it is.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    valid && !ready |=> valid && $stable(row_index) && $stable(comp_x) &&
      $stable(comp_y) && $stable(comp_z) && $stable(offset) &&
      $stable(degenerate) && $stable(last_row))
    else $error("row output changed while stalled");

  // Within an item the rows follow at once and in order.
  a_row_order: assert property (@(posedge clk) disable iff (rst)
    valid && ready && !last_row |=> valid && (row_index == $past(row_index) + 2'd1))
    else $error("row sequence broken within an item");

  // A new item starts at the side row.
  a_row_start: assert property (@(posedge clk) disable iff (rst)
    valid && ready && last_row |=> !valid || (row_index == lavb_pkg::ROW_SIDE))
    else $error("item did not start at the side row");

  // The degenerate flag is the same on all rows of one item.
  a_degen: assert property (@(posedge clk) disable iff (rst)
    valid && ready && !last_row |=> degenerate == $past(degenerate))
    else $error("degenerate flag changed within an item");

endmodule

bind look_at_view_basis lavb_check u_lavb_check (
  .clk(clk),
  .rst(rst),
  .valid(rows.valid),
  .ready(rows.ready),
  .row_index(rows.row_index),
  .comp_x(rows.comp_x),
  .comp_y(rows.comp_y),
  .comp_z(rows.comp_z),
  .offset(rows.offset),
  .degenerate(rows.degenerate),
  .last_row(rows.last_row)
);
